// File: rtl/core/hrsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrsr_pkg
// shared types and fixed constants of the history ring readout
// ----------------------------------------------------------------------------
package hrsr_pkg;

   // fixed field widths
   localparam int SIZE_W      = 8;
   localparam int COUNT_OUT_W = 8;

   // capacity in use after reset
   localparam int INIT_CAPACITY = 10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COPY,
      ST_APPEND,
      ST_ADVANCE,
      ST_SCALE,
      ST_FETCH,
      ST_FINISH
   } hrsr_state_type;

endpackage

// File: rtl/core/hrsr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrsr_if
// request and response channels of the history ring readout
// ----------------------------------------------------------------------------
interface hrsr_req_if import hrsr_pkg::*; #(
   parameter int POS_W  = 17,
   parameter int DATA_W = 32
) ();
   logic              valid;
   logic              ready;
   logic [POS_W-1:0]  read_position;
   logic [SIZE_W-1:0] buffer_size;
   logic              record;
   logic [DATA_W-1:0] data_word;

   modport source (output valid, read_position, buffer_size, record, data_word,
                   input ready);
   modport sink   (input valid, read_position, buffer_size, record, data_word,
                   output ready);
endinterface

interface hrsr_rsp_if import hrsr_pkg::*; #(
   parameter int DATA_W = 32
) ();
   logic                   valid;
   logic                   ready;
   logic                   has_data;
   logic [DATA_W-1:0]      read_word;
   logic [COUNT_OUT_W-1:0] stored_count;

   modport source (output valid, has_data, read_word, stored_count, input ready);
   modport sink   (input valid, has_data, read_word, stored_count, output ready);
endinterface

// File: rtl/core/hrsr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrsr_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module hrsr_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 250,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/hrsr_modadd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrsr_modadd
// shared ring pointer unit: (a + b) mod m for a < m and b <= m
// ----------------------------------------------------------------------------
module hrsr_modadd #(
   parameter int W = 8
) (
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   input  logic [W-1:0] modulus,
   output logic [W-1:0] sum
);

   logic [W:0] raw;
   logic [W:0] wrapped;

   always_comb begin
      raw     = {1'b0, a} + {1'b0, b};
      wrapped = raw - {1'b0, modulus};
      // one compare and subtract is enough since the sum stays below 2m
      sum     = (raw >= {1'b0, modulus}) ? wrapped[W-1:0] : raw[W-1:0];
   end

endmodule

// File: rtl/core/history_ring_scaled_readout.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// history_ring_scaled_readout
// overwriting history ring with resize and scaled-position readout
// ----------------------------------------------------------------------------
//
//   channel    direction  handshake            payload
//   req_chan   in         valid/ready          read_position, buffer_size,
//                                              record, data_word
//   rsp_chan   out        valid/ready          has_data, read_word,
//                                              stored_count
//
// an item steps through append, advance (only when an append overwrites the
// oldest entry), scale, fetch (skipped when the ring is still empty after
// the append step, no ram fetch) and finish; a size change first runs the
// copy step, which carries over keep entries (keep = entries carried over,
// below MAX_DEPTH), one entry copied per cycle through the ram ports
// the ring lives in two ram banks; a resize copies the active bank into
// the other one starting at slot 0 and then swaps the banks
// reset clears the control state only, the ram is never cleared
// a response that is not taken holds the sequencer in its last step
//
module history_ring_scaled_readout import hrsr_pkg::*; #(
   parameter int MAX_DEPTH     = 250,
   parameter int DATA_WIDTH    = 32,
   parameter int POS_FRAC_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   hrsr_req_if.sink   req_chan,
   hrsr_rsp_if.source rsp_chan
);

   localparam int POS_W    = POS_FRAC_BITS + 1;
   localparam int CNT_W    = $clog2(MAX_DEPTH + 1);
   localparam int ADDR_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int CMP_W    = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
   localparam int PROD_W   = POS_W + CNT_W;
   localparam int INIT_CAP = (INIT_CAPACITY < MAX_DEPTH) ? INIT_CAPACITY : MAX_DEPTH;
   localparam logic [POS_W-1:0] POS_ONE = POS_W'(1) << POS_FRAC_BITS;

   // sequencer state
   hrsr_state_type state_ff, state_in;

   // ring state
   logic                  bank_ff, bank_in;
   logic [CNT_W-1:0]      oldest_ff, oldest_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      cap_ff, cap_in;

   // captured item
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [CNT_W-1:0]      cap_req_ff, cap_req_in;
   logic                  record_ff, record_in;
   logic [DATA_WIDTH-1:0] word_ff, word_in;

   // resize copy and readout
   logic [CNT_W-1:0]      keep_ff, keep_in;
   logic [CNT_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]      wr_idx_ff, wr_idx_in;
   logic                  copy_pend_ff, copy_pend_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_has_ff, rsp_has_in;
   logic [DATA_WIDTH-1:0]  rsp_word_ff, rsp_word_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   // handshakes
   logic req_xfer;
   logic rsp_free;

   // request decode
   logic [CMP_W-1:0] size_ext;
   logic [CMP_W-1:0] size_clamped;
   logic [CNT_W-1:0] cap_req_now;
   logic [POS_W-1:0] pos_clamped;

   // shared pointer unit
   logic [CNT_W-1:0] alu_b;
   logic [CNT_W-1:0] alu_sum;

   // scaled index
   logic [PROD_W-1:0] product;

   // ram access, single source muxed onto the banks
   logic                  wr_en_c;
   logic                  wr_bank_c;
   logic [ADDR_W-1:0]     wr_addr_c;
   logic [DATA_WIDTH-1:0] wr_data_c;
   logic                  rd_en_c;
   logic [ADDR_W-1:0]     rd_addr_c;
   logic [DATA_WIDTH-1:0] rd_data_active;
   logic [DATA_WIDTH-1:0] ram_rdata [2];

   // copy progress
   logic copy_issue;
   logic copy_done;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.has_data     = rsp_has_ff;
   assign rsp_chan.read_word    = rsp_word_ff;
   assign rsp_chan.stored_count = rsp_count_ff;

   // clamp size to 1..MAX_DEPTH and position to 1.0
   always_comb begin
      size_ext = CMP_W'(req_chan.buffer_size);
      if (size_ext == '0) begin
         size_clamped = CMP_W'(1);
      end else if (size_ext > CMP_W'(MAX_DEPTH)) begin
         size_clamped = CMP_W'(MAX_DEPTH);
      end else begin
         size_clamped = size_ext;
      end
      cap_req_now = CNT_W'(size_clamped);
      pos_clamped = (req_chan.read_position > POS_ONE) ? POS_ONE : req_chan.read_position;
   end

   assign copy_issue = (rd_idx_ff != keep_ff);
   assign copy_done  = !copy_issue && !copy_pend_ff;

   // second operand of the pointer unit, first is always the oldest slot
   always_comb begin
      case (state_ff)
         ST_COPY:    alu_b = rd_idx_ff;
         ST_APPEND:  alu_b = count_ff;
         ST_ADVANCE: alu_b = CNT_W'(1);
         default:    alu_b = idx_ff;
      endcase
   end

   hrsr_modadd #(
      .W (CNT_W)
   ) u_modadd (
      .a       (oldest_ff),
      .b       (alu_b),
      .modulus (cap_ff),
      .sum     (alu_sum)
   );

   // pos * (count - 1), floor by dropping the fraction bits
   assign product = PROD_W'(pos_ff) * PROD_W'(count_ff - CNT_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = (cap_req_now != cap_ff) ? ST_COPY : ST_APPEND;
            end
         end
         ST_COPY: begin
            if (copy_done) begin
               state_in = ST_APPEND;
            end
         end
         ST_APPEND: begin
            state_in = (record_ff && (count_ff >= cap_ff)) ? ST_ADVANCE : ST_SCALE;
         end
         ST_ADVANCE: begin
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            state_in = (count_ff == '0) ? ST_FINISH : ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and ram control
   always_comb begin
      bank_in      = bank_ff;
      oldest_in    = oldest_ff;
      count_in     = count_ff;
      cap_in       = cap_ff;
      pos_in       = pos_ff;
      cap_req_in   = cap_req_ff;
      record_in    = record_ff;
      word_in      = word_ff;
      keep_in      = keep_ff;
      rd_idx_in    = rd_idx_ff;
      wr_idx_in    = wr_idx_ff;
      copy_pend_in = copy_pend_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_has_in   = rsp_has_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_count_in = rsp_count_ff;

      wr_en_c   = 1'b0;
      wr_bank_c = bank_ff;
      wr_addr_c = alu_sum[ADDR_W-1:0];
      wr_data_c = word_ff;
      rd_en_c   = 1'b0;
      rd_addr_c = alu_sum[ADDR_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               pos_in       = pos_clamped;
               cap_req_in   = cap_req_now;
               record_in    = req_chan.record;
               word_in      = req_chan.data_word;
               keep_in      = (count_ff < cap_req_now) ? count_ff : cap_req_now;
               rd_idx_in    = '0;
               copy_pend_in = 1'b0;
            end
         end
         ST_COPY: begin
            // read oldest+i from the active bank, write slot i of the other
            rd_en_c      = copy_issue;
            rd_idx_in    = copy_issue ? CNT_W'(rd_idx_ff + CNT_W'(1)) : rd_idx_ff;
            copy_pend_in = copy_issue;
            wr_idx_in    = rd_idx_ff;
            wr_en_c      = copy_pend_ff;
            wr_bank_c    = !bank_ff;
            wr_addr_c    = wr_idx_ff[ADDR_W-1:0];
            wr_data_c    = rd_data_active;
            if (copy_done) begin
               bank_in   = !bank_ff;
               oldest_in = '0;
               count_in  = keep_ff;
               cap_in    = cap_req_ff;
            end
         end
         ST_APPEND: begin
            if (record_ff) begin
               wr_en_c = 1'b1;
               if (count_ff < cap_ff) begin
                  count_in = CNT_W'(count_ff + CNT_W'(1));
               end
            end
         end
         ST_ADVANCE: begin
            // ring was full, the append overwrote the oldest entry
            oldest_in = alu_sum;
         end
         ST_SCALE: begin
            idx_in = product[POS_FRAC_BITS +: CNT_W];
         end
         ST_FETCH: begin
            rd_en_c = 1'b1;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_has_in   = (count_ff != '0);
               rsp_word_in  = (count_ff != '0) ? rd_data_active : '0;
               rsp_count_in = COUNT_OUT_W'(count_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // two ring banks, reads always from the active one
   for (genvar b = 0; b < 2; b++) begin : g_bank
      hrsr_ram #(
         .WIDTH (DATA_WIDTH),
         .DEPTH (MAX_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en_c && (wr_bank_c == 1'(b))),
         .wr_addr (wr_addr_c),
         .wr_data (wr_data_c),
         .rd_en   (rd_en_c && (bank_ff == 1'(b))),
         .rd_addr (rd_addr_c),
         .rd_data (ram_rdata[b])
      );
   end

   assign rd_data_active = bank_ff ? ram_rdata[1] : ram_rdata[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bank_ff      <= 1'b0;
         oldest_ff    <= '0;
         count_ff     <= '0;
         cap_ff       <= CNT_W'(INIT_CAP);
         copy_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bank_ff      <= bank_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         copy_pend_ff <= copy_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      cap_req_ff   <= cap_req_in;
      record_ff    <= record_in;
      word_ff      <= word_in;
      keep_ff      <= keep_in;
      rd_idx_ff    <= rd_idx_in;
      wr_idx_ff    <= wr_idx_in;
      idx_ff       <= idx_in;
      rsp_has_ff   <= rsp_has_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_count_ff <= rsp_count_in;
   end

endmodule
